/* hdl/tvd_pkg.sv */
// Shared types and constants of the TVD slope limiter.
package tvd_pkg;

  localparam int ModeW      = 3;
  localparam int ApbDataW   = 32;
  localparam int CfgAddrW   = 3;
  localparam int MulChunk   = 16;
  localparam int QueueDepth = 2;

  localparam logic [CfgAddrW-3:0] RegLimiterMode = '0;

  typedef enum logic [ModeW-1:0] {
    MODE_MINMOD2    = 3'd0,
    MODE_SUPERBEE   = 3'd1,
    MODE_MINMOD3    = 3'd2,
    MODE_VAN_LEER   = 3'd3,
    MODE_VAN_ALBADA = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_ZERO       = 2'd0,
    KIND_DIRECT     = 2'd1,
    KIND_VAN_LEER   = 2'd2,
    KIND_VAN_ALBADA = 2'd3
  } kind_e;

  typedef struct packed {
    logic  neg;
    kind_e kind;
  } ctl_t;

endpackage

/* hdl/tvd_ifs.sv */
// Stream channel interfaces for slope sets and limited slopes.
interface tvd_in_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] slope_a;
  logic signed [DATA_WIDTH-1:0] slope_b;
  logic signed [DATA_WIDTH-1:0] slope_c;

  modport source (output valid, output slope_a, output slope_b, output slope_c, input ready);
  modport sink (input valid, input slope_a, input slope_b, input slope_c, output ready);
endinterface

interface tvd_out_if #(parameter int DATA_WIDTH = 32) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] limited_slope;

  modport source (output valid, output limited_slope, input ready);
  modport sink (input valid, input limited_slope, output ready);
endinterface

/* hdl/tvd_slope_limiter.sv */
// Top level of the TVD slope limiter with its APB configuration register.
// Takes one slope set per cycle while the output is taken and returns one limited
// slope per set, in order. The back pipeline runs a one-bit-per-stage divider
// behind the chunked product multipliers. A two-entry queue between the
// classifying front stage and the arithmetic back pipeline absorbs output stalls.
// limiter_mode sits at byte address 0 and may be written only while idle.
module tvd_slope_limiter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  tvd_in_if.sink                          in_i,
  tvd_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tvd_pkg::CfgAddrW-1:0]    paddr,
  input  logic [tvd_pkg::ApbDataW-1:0]    pwdata,
  output logic [tvd_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import tvd_pkg::*;

  localparam int JobW = $bits(ctl_t) + 3 * DATA_WIDTH + 1;

  logic [ModeW-1:0]      mode_q;
  logic                  f_valid, f_ready, q_valid, q_ready;
  ctl_t                  f_ctl, q_ctl;
  logic [DATA_WIDTH-1:0] f_ma, f_mb, q_ma, q_mb;
  logic [DATA_WIDTH:0]   f_dmag, q_dmag;
  logic [JobW-1:0]       q_data;

  assign pready = 1'b1;
  assign prdata = (paddr[CfgAddrW-1:2] == RegLimiterMode) ? ApbDataW'(mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MINMOD2;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CfgAddrW-1:2] == RegLimiterMode) begin
      mode_q <= pwdata[ModeW-1:0];
    end
  end

  tvd_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .mode_i  (mode_q),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .ctl_o   (f_ctl),
    .ma_o    (f_ma),
    .mb_o    (f_mb),
    .dmag_o  (f_dmag)
  );

  tvd_queue #(.DATA_W(JobW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   ({f_ctl, f_ma, f_mb, f_dmag}),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  assign {q_ctl, q_ma, q_mb, q_dmag} = q_data;

  tvd_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .ctl_i      (q_ctl),
    .ma_i       (q_ma),
    .mb_i       (q_mb),
    .dmag_i     (q_dmag),
    .out_o      (out_o)
  );

endmodule

/* hdl/tvd_front.sv */
// Front stage: splits slopes into sign and magnitude and classifies the job.
module tvd_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tvd_in_if.sink                       in_i,
  input  logic [tvd_pkg::ModeW-1:0]    mode_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output tvd_pkg::ctl_t                ctl_o,
  output logic [DATA_WIDTH-1:0]        ma_o,
  output logic [DATA_WIDTH-1:0]        mb_o,
  output logic [DATA_WIDTH:0]          dmag_o
);
  import tvd_pkg::*;

  logic                  na, nb, nc, same2, same3;
  logic [DATA_WIDTH-1:0] ma, mb, mc, min2, min3;
  logic [DATA_WIDTH:0]   a2, b2, t1, t2, sb;
  ctl_t                  ctl_d;
  logic [DATA_WIDTH:0]   dmag_d;
  logic                  valid_q;
  ctl_t                  ctl_q;
  logic [DATA_WIDTH-1:0] ma_q, mb_q;
  logic [DATA_WIDTH:0]   dmag_q;

  assign na = in_i.slope_a[DATA_WIDTH-1];
  assign nb = in_i.slope_b[DATA_WIDTH-1];
  assign nc = in_i.slope_c[DATA_WIDTH-1];
  assign ma = na ? DATA_WIDTH'(~in_i.slope_a + 1'b1) : DATA_WIDTH'(in_i.slope_a);
  assign mb = nb ? DATA_WIDTH'(~in_i.slope_b + 1'b1) : DATA_WIDTH'(in_i.slope_b);
  assign mc = nc ? DATA_WIDTH'(~in_i.slope_c + 1'b1) : DATA_WIDTH'(in_i.slope_c);

  assign same2 = (ma != '0) && (mb != '0) && (na == nb);
  assign same3 = same2 && (mc != '0) && (nb == nc);

  assign min2 = (ma < mb) ? ma : mb;
  assign min3 = (mc < min2) ? mc : min2;
  assign a2   = {ma, 1'b0};
  assign b2   = {mb, 1'b0};
  assign t1   = (a2 < {1'b0, mb}) ? a2 : {1'b0, mb};
  assign t2   = ({1'b0, ma} < b2) ? {1'b0, ma} : b2;
  assign sb   = (t1 > t2) ? t1 : t2;

  always_comb begin
    ctl_d.neg  = na;
    ctl_d.kind = KIND_ZERO;
    dmag_d     = '0;
    unique case (mode_e'(mode_i))
      MODE_SUPERBEE: begin
        if (same2) begin
          ctl_d.kind = KIND_DIRECT;
          dmag_d     = sb;
        end
      end
      MODE_MINMOD3: begin
        if (same3) begin
          ctl_d.kind = KIND_DIRECT;
          dmag_d     = {1'b0, min3};
        end
      end
      MODE_VAN_LEER: begin
        if (same2) ctl_d.kind = KIND_VAN_LEER;
      end
      MODE_VAN_ALBADA: begin
        if (same2) ctl_d.kind = KIND_VAN_ALBADA;
      end
      default: begin
        if (same2) begin
          ctl_d.kind = KIND_DIRECT;
          dmag_d     = {1'b0, min2};
        end
      end
    endcase
  end

  assign in_i.ready = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      ctl_q  <= ctl_d;
      ma_q   <= ma;
      mb_q   <= mb;
      dmag_q <= dmag_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign ma_o    = ma_q;
  assign mb_o    = mb_q;
  assign dmag_o  = dmag_q;

endmodule

/* hdl/tvd_queue.sv */
// Short FIFO between the front and back stages.
module tvd_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DATA_W-1:0] in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DATA_W-1:0] out_data_o
);
  import tvd_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wp_q, rp_q;
  logic [PtrW:0]     cnt_q;
  logic              push, pop;

  assign in_ready_o  = cnt_q != (PtrW+1)'(QueueDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop) rp_q <= rp_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

endmodule

/* hdl/tvd_mul.sv */
// Pipelined unsigned multiplier, one chunk of the second operand per stage.
module tvd_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);
  import tvd_pkg::*;

  localparam int NS  = (BW + MulChunk - 1) / MulChunk;
  localparam int BWP = NS * MulChunk;
  localparam int PW  = AW + BW;

  logic [AW-1:0]  a_in [NS];
  logic [AW-1:0]  a_q  [NS];
  logic [BWP-1:0] b_in [NS];
  logic [BWP-1:0] b_q  [NS];
  logic [PW-1:0]  acc_in [NS];
  logic [PW-1:0]  acc_q  [NS];

  assign a_in[0]   = a_i;
  assign b_in[0]   = BWP'(b_i);
  assign acc_in[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [AW+MulChunk-1:0] pp;
    if (k > 0) begin : g_link
      assign a_in[k]   = a_q[k-1];
      assign b_in[k]   = b_q[k-1];
      assign acc_in[k] = acc_q[k-1];
    end
    assign pp = a_in[k] * b_in[k][k*MulChunk +: MulChunk];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]   <= a_in[k];
        b_q[k]   <= b_in[k];
        acc_q[k] <= acc_in[k] + (PW'(pp) << (k * MulChunk));
      end
    end
  end

  assign p_o = acc_q[NS-1];

endmodule

/* hdl/tvd_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module tvd_div #(
  parameter int NUM_W  = 97,
  parameter int DEN_W  = 65,
  parameter int QUO_W  = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [QUO_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem_in  [QUO_W];
  logic [DEN_W-1:0]  rem_q   [QUO_W];
  logic [DEN_W-1:0]  den_in  [QUO_W];
  logic [DEN_W-1:0]  den_q   [QUO_W];
  logic [QUO_W-1:0]  low_in  [QUO_W];
  logic [QUO_W-1:0]  low_q   [QUO_W];
  logic [QUO_W-1:0]  quo_in  [QUO_W];
  logic [QUO_W-1:0]  quo_q   [QUO_W];
  logic [SIDE_W-1:0] side_in [QUO_W];
  logic [SIDE_W-1:0] side_q  [QUO_W];

  assign rem_in[0]  = DEN_W'(num_i[NUM_W-1:QUO_W]);
  assign low_in[0]  = num_i[QUO_W-1:0];
  assign quo_in[0]  = '0;
  assign den_in[0]  = den_i;
  assign side_in[0] = side_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    if (k > 0) begin : g_link
      assign rem_in[k]  = rem_q[k-1];
      assign low_in[k]  = low_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign side_in[k] = side_q[k-1];
    end
    assign trial = {rem_in[k], low_in[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_in[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DEN_W'(trial - {1'b0, den_in[k]}) : DEN_W'(trial);
        low_q[k]  <= low_in[k] << 1;
        quo_q[k]  <= {quo_in[k][QUO_W-2:0], ge};
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign quo_o  = quo_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

/* hdl/tvd_back.sv */
// Back pipeline: products, ratio division, result select, saturation, output register.
module tvd_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tvd_pkg::ctl_t         ctl_i,
  input  logic [DATA_WIDTH-1:0] ma_i,
  input  logic [DATA_WIDTH-1:0] mb_i,
  input  logic [DATA_WIDTH:0]   dmag_i,
  tvd_out_if.source             out_o
);
  import tvd_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int LA   = (W + MulChunk - 1) / MulChunk;
  localparam int LB   = (W + 1 + MulChunk - 1) / MulChunk;
  localparam int QW   = W + 1;
  localparam int NW   = 3 * W + 1;
  localparam int DVW  = 2 * W + 1;
  localparam int NST  = LA + LB + QW;
  localparam int SW   = $bits(ctl_t) + W + 1;

  logic           adv;
  logic [NST-1:0] vld_q;

  ctl_t           ctla_q [LA];
  logic [W:0]     dmaga_q [LA];
  logic [W:0]     sa_q [LA];
  logic [2*W-1:0] ab, aa, bb;

  ctl_t           ctlb_q [LB];
  logic [W:0]     dmagb_q [LB];
  logic [W:0]     sb_q [LB];
  logic [DVW-1:0] dvab_q [LB];
  logic [2*W-1:0] abb_q [LB];
  logic [NW-1:0]  nva;

  logic [NW-1:0]  div_num;
  logic [DVW-1:0] div_den;
  logic [QW-1:0]  quo;
  logic [SW-1:0]  side_out;
  ctl_t           ctl_f;
  logic [W:0]     dmag_f, mag_f;
  logic [W-1:0]   res_d;

  logic           out_valid_q;
  logic [W-1:0]   res_q;

  localparam logic [W:0] SignMag = (W+1)'(1) << (W - 1);
  localparam logic [W:0] PosMax  = SignMag - 1'b1;

  assign adv        = !out_valid_q || out_o.ready;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[NST-2:0], in_valid_i};
      out_valid_q <= vld_q[NST-1];
    end
  end

  tvd_mul #(.AW(W), .BW(W)) u_mul_ab (
    .clk_i(clk_i), .en_i(adv), .a_i(ma_i), .b_i(mb_i), .p_o(ab)
  );
  tvd_mul #(.AW(W), .BW(W)) u_mul_aa (
    .clk_i(clk_i), .en_i(adv), .a_i(ma_i), .b_i(ma_i), .p_o(aa)
  );
  tvd_mul #(.AW(W), .BW(W)) u_mul_bb (
    .clk_i(clk_i), .en_i(adv), .a_i(mb_i), .b_i(mb_i), .p_o(bb)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctla_q[0]  <= ctl_i;
      dmaga_q[0] <= dmag_i;
      sa_q[0]    <= {1'b0, ma_i} + {1'b0, mb_i};
      for (int k = 1; k < LA; k++) begin
        ctla_q[k]  <= ctla_q[k-1];
        dmaga_q[k] <= dmaga_q[k-1];
        sa_q[k]    <= sa_q[k-1];
      end
    end
  end

  tvd_mul #(.AW(2 * W), .BW(W + 1)) u_mul_num (
    .clk_i(clk_i), .en_i(adv), .a_i(ab), .b_i(sa_q[LA-1]), .p_o(nva)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctlb_q[0]  <= ctla_q[LA-1];
      dmagb_q[0] <= dmaga_q[LA-1];
      sb_q[0]    <= sa_q[LA-1];
      dvab_q[0]  <= {1'b0, aa} + {1'b0, bb};
      abb_q[0]   <= ab;
      for (int k = 1; k < LB; k++) begin
        ctlb_q[k]  <= ctlb_q[k-1];
        dmagb_q[k] <= dmagb_q[k-1];
        sb_q[k]    <= sb_q[k-1];
        dvab_q[k]  <= dvab_q[k-1];
        abb_q[k]   <= abb_q[k-1];
      end
    end
  end

  always_comb begin
    if (ctlb_q[LB-1].kind == KIND_VAN_ALBADA) begin
      div_num = nva;
      div_den = dvab_q[LB-1];
    end else begin
      div_num = NW'({abb_q[LB-1], 1'b0});
      div_den = DVW'(sb_q[LB-1]);
    end
  end

  tvd_div #(.NUM_W(NW), .DEN_W(DVW), .QUO_W(QW), .SIDE_W(SW)) u_div (
    .clk_i  (clk_i),
    .en_i   (adv),
    .num_i  (div_num),
    .den_i  (div_den),
    .side_i ({ctlb_q[LB-1], dmagb_q[LB-1]}),
    .quo_o  (quo),
    .side_o (side_out)
  );

  assign {ctl_f, dmag_f} = side_out;

  always_comb begin
    unique case (ctl_f.kind)
      KIND_ZERO:   mag_f = '0;
      KIND_DIRECT: mag_f = dmag_f;
      default:     mag_f = quo;
    endcase
    if (mag_f == '0) begin
      res_d = '0;
    end else if (ctl_f.neg) begin
      res_d = (mag_f > SignMag) ? W'(~SignMag + 1'b1) : W'(~mag_f + 1'b1);
    end else begin
      res_d = (mag_f > PosMax) ? W'(PosMax) : W'(mag_f);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.limited_slope = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[NST-1] && ctl_f.kind == KIND_ZERO) |=> (out_o.limited_slope == '0))
    else $error("zero-class item produced a nonzero slope");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && vld_q[NST-1] && !ctl_f.neg) |=> !out_o.limited_slope[W-1])
    else $error("positive slopes produced a negative result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST-1] && ctl_f.kind == KIND_VAN_ALBADA) |-> !quo[QW-1])
    else $error("van Albada quotient exceeds slope range");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for tvd_slope_limiter: random and directed slope sets checked against a local predictor.
module testbench;
  import tvd_pkg::*;

  localparam int W = 32;
  localparam int LATENCY = 40;
  localparam longint MAX_CYCLES = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tvd_in_if #(.DATA_WIDTH(W)) in_ch ();
  tvd_out_if #(.DATA_WIDTH(W)) out_ch ();

  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  tvd_slope_limiter #(.DATA_WIDTH(W)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [W-1:0] expected_slopes[$];
  logic [ModeW-1:0] mode_raw = '0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  longint cycle = 0;
  bit stall_on = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.slope_a = '0;
    in_ch.slope_b = '0;
    in_ch.slope_c = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [63:0] magnitude(logic signed [W-1:0] v);
    return v[W-1] ? 64'(-{{32{v[W-1]}}, v}) : 64'(v);
  endfunction

  // floor(s*p/d) on wide integers
  function automatic logic [63:0] scaled_quotient(logic [63:0] s, logic [191:0] p,
                                                  logic [191:0] d);
    logic [255:0] num;
    num = 256'(s) * 256'(p);
    return 64'(num / 256'(d));
  endfunction

  function automatic logic signed [W-1:0] limit_slope(logic signed [W-1:0] a,
      logic signed [W-1:0] b, logic signed [W-1:0] c, logic [ModeW-1:0] mode);
    logic [63:0] ma, mb, mc, mag, t1, t2;
    logic [191:0] p, d;
    logic na, nb, nc, neg, same2;
    ma = magnitude(a); mb = magnitude(b); mc = magnitude(c);
    na = a[W-1]; nb = b[W-1]; nc = c[W-1];
    same2 = ma != 0 && mb != 0 && na == nb;
    neg = 1'b0;
    mag = 0;
    case (mode)
      MODE_SUPERBEE: if (same2) begin
        t1 = (2 * ma < mb) ? 2 * ma : mb;
        t2 = (ma < 2 * mb) ? ma : 2 * mb;
        neg = na;
        mag = t1 > t2 ? t1 : t2;
      end
      MODE_MINMOD3: if (ma != 0 && mb != 0 && mc != 0 && na == nb && nb == nc) begin
        neg = na;
        mag = ma < mb ? ma : mb;
        if (mc < mag) mag = mc;
      end
      MODE_VAN_LEER: if (same2) begin
        neg = na;
        mag = scaled_quotient(mb, 192'(2 * ma), 192'(ma + mb));
      end
      MODE_VAN_ALBADA: if (same2) begin
        p = 192'(ma) * 192'(mb);
        d = 192'(ma) * 192'(ma) + 192'(mb) * 192'(mb);
        neg = na;
        mag = scaled_quotient(ma + mb, p, d);
      end
      default: if (same2) begin
        neg = na;
        mag = ma < mb ? ma : mb;
      end
    endcase
    if (mag == 0) return '0;
    if (neg) return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : W'(-mag);
    return (mag > 64'h7fff_ffff) ? 32'sh7fff_ffff : W'(mag);
  endfunction

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle);
      $display("FAIL tvd_slope_limiter");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (!stall_on) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0) || (cycle[7:5] == 3'd2);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_slopes.size() == 0) begin
        $display("%0t: unexpected transfer, actual %0d", $time, out_ch.limited_slope);
        errors++;
      end else begin
        if (expected_slopes[0] !== out_ch.limited_slope) begin
          $display("%0t: limited_slope mismatch, expected %0d actual %0d", $time,
                   expected_slopes[0], out_ch.limited_slope);
          errors++;
        end
        void'(expected_slopes.pop_front());
        n_checked++;
      end
    end
  end

  task automatic send_slopes(logic signed [W-1:0] a, logic signed [W-1:0] b,
                             logic signed [W-1:0] c);
    in_ch.valid <= 1'b1;
    in_ch.slope_a <= a;
    in_ch.slope_b <= b;
    in_ch.slope_c <= c;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_slopes.push_back(limit_slope(a, b, c, mode_raw));
    n_sent++;
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    idle_input();
    while (expected_slopes.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_mode(logic [ModeW-1:0] m);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {RegLimiterMode, 2'b00};
    pwdata <= {$urandom} & ~32'h7 | 32'(m);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mode_raw = m;
    @(posedge clk_i);
    if (prdata[ModeW-1:0] !== m) begin
      $display("%0t: mode readback mismatch, expected %0d actual %0d", $time, m,
               prdata[ModeW-1:0]);
      errors++;
    end
  endtask

  function automatic logic signed [W-1:0] rand_slope();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return $signed(32'($urandom_range(1, 300)));
      4: return -$signed(32'($urandom_range(1, 300)));
      5: return $signed(32'($urandom_range(0, 32'h3_0000))) - 32'sh1_8000;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [W-1:0] ext[6];
    ext = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 32'sh0001_0000};
    for (int m = 0; m < 8; m++) begin
      if (m != 0) drain();
      write_mode(m[ModeW-1:0]);
      for (int k = 0; k < 3; k++) send_slopes(ext[$urandom_range(0, 5)],
                                              ext[$urandom_range(0, 5)],
                                              ext[$urandom_range(0, 5)]);
    end
    send_slopes(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_slopes(32'sh7fff_ffff, 32'sh7fff_ffff, 1);
    send_slopes(5, -5, 5);
    drain();
  endtask

  task automatic test_random_mode(logic [ModeW-1:0] m, int count);
    int burst;
    write_mode(m);
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && count > 0; k++, count--) begin
        if ($urandom_range(0, 2) == 0)
          send_slopes(rand_slope(), rand_slope(), rand_slope());
        else if ($urandom_range(0, 1))
          send_slopes($urandom, $urandom, $urandom);
        else
          send_slopes(-$signed(32'($urandom_range(1, 32'h7fff_ffff))),
                      -$signed(32'($urandom_range(1, 32'h7fff_ffff))),
                      -$signed(32'($urandom_range(1, 32'h7fff_ffff))));
      end
      if ($urandom_range(0, 9) == 0) while (expected_slopes.size() != 0) idle_input();
      repeat ($urandom_range(0, 4)) idle_input();
    end
    drain();
  endtask

  task automatic test_full_rate();
    stall_on = 1'b0;
    write_mode(MODE_VAN_ALBADA);
    repeat (60) send_slopes(rand_slope(), rand_slope(), rand_slope());
    drain();
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    for (int m = 0; m < 8; m++) test_random_mode(m[ModeW-1:0], 80);
    test_full_rate();
    test_random_mode(MODE_MINMOD2, 10);
    $display("sent %0d slope sets over all eight limiter modes, %0d results checked",
             n_sent, n_checked);
    if (errors == 0 && expected_slopes.size() == 0) $display("PASS tvd_slope_limiter");
    else $display("FAIL tvd_slope_limiter");
    $finish;
  end
endmodule

/* filelist.f */
hdl/tvd_pkg.sv
hdl/tvd_ifs.sv
hdl/tvd_front.sv
hdl/tvd_queue.sv
hdl/tvd_mul.sv
hdl/tvd_div.sv
hdl/tvd_back.sv
hdl/tvd_slope_limiter.sv
tb/sv/testbench.sv
